@@ rtl/sqe_pkg.sv @@
// Shared types, character constants and byte classification for the string quote escaper.
package sqe_pkg;

  // Pass codes carried on the operation field
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  // Characters used by the quoting and escaping rules
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_NEWLINE   = 8'h0a;
  localparam logic [7:0] CH_CR        = 8'h0d;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_LOWER_N   = 8'h6e;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_X   = 8'h78;
  localparam logic [7:0] CH_DIGIT0    = 8'h30;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] PRINT_LO     = 8'd32;
  localparam logic [7:0] PRINT_HI     = 8'd126;

  // Result segments: opening quotes, one per window byte, closing quotes
  localparam int NUM_SEGS  = 6;
  localparam int WIN_BYTES = 4;
  localparam logic [2:0] SEG_OPEN  = 3'd0;
  localparam logic [2:0] SEG_CLOSE = 3'd5;

  // One segment: up to four output characters, emitted from index 0
  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] chars;
  } seg_t;

  // Length of a UTF-8 sequence started by a lead byte, zero if not a lead
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    if (b[7:5] == 3'b110) n = 3'd2;
    else if (b[7:4] == 4'b1110) n = 3'd3;
    else if (b[7:3] == 5'b11110) n = 3'd4;
    return n;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) c = CH_DIGIT0 + {4'b0000, nib};
    else c = CH_LOWER_A + {4'b0000, nib} - 8'd10;
    return c;
  endfunction

  // Repeat one character to fill a segment of the given length
  function automatic seg_t quote_seg(input logic [7:0] q, input logic [2:0] len);
    seg_t s;
    s.len   = len;
    s.chars = {q, q, q, q};
    return s;
  endfunction

  function automatic seg_t raw_seg(input logic [7:0] b);
    seg_t s;
    s.len      = 3'd1;
    s.chars    = '0;
    s.chars[0] = b;
    return s;
  endfunction

  // Escape one byte that is not part of a UTF-8 run
  function automatic seg_t escape_seg(input logic [7:0] b, input logic [7:0] q,
                                      input logic triple);
    seg_t s;
    s.len      = 3'd2;
    s.chars    = '0;
    s.chars[0] = CH_BACKSLASH;
    if (b == CH_NEWLINE) begin
      if (triple) begin
        s.len      = 3'd1;
        s.chars[0] = b;
      end else begin
        s.chars[1] = CH_LOWER_N;
      end
    end else if (b == CH_CR) begin
      s.chars[1] = CH_LOWER_R;
    end else if (b == CH_TAB) begin
      s.chars[1] = CH_LOWER_T;
    end else if (b == CH_BACKSLASH) begin
      s.chars[1] = CH_BACKSLASH;
    end else if (b == q) begin
      s.chars[1] = q;
    end else if (b < PRINT_LO || b > PRINT_HI) begin
      s.len      = 3'd4;
      s.chars[1] = CH_LOWER_X;
      s.chars[2] = hex_char(b[7:4]);
      s.chars[3] = hex_char(b[3:0]);
    end else begin
      s.len      = 3'd1;
      s.chars[0] = b;
    end
    return s;
  endfunction

endpackage

@@ rtl/string_quote_escaper_unit.sv @@
// Top level of the string quote escaper: input register, escape logic, output serializer.
// An accepted beat is held in the input register until it moves on; its first output byte
//   is valid in the cycle after it moves on.
// A beat that produces no output (scan pass, held UTF-8 lead) moves on without waiting;
//   else the serializer gives one byte per cycle while out_ready holds, 1 to 19 per beat.
// Reset clears the quote flags, the lookahead window and all valid bits.
module string_quote_escaper_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_string,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_final
);

  // Input register
  logic       in_valid_r;
  logic       in_op_r;
  logic [7:0] in_byte_r;
  logic       in_eos_r;

  // String state
  logic       dq_r, sq_r, nl_r, opened_r;
  logic [7:0] la_r [3];
  logic [1:0] la_cnt_r;
  logic       dq_nxt, sq_nxt, nl_nxt, opened_nxt;
  logic [7:0] la_nxt [3];
  logic [1:0] la_cnt_nxt;

  // Serializer
  logic                res_valid_r;
  sqe_pkg::seg_t       seg_r [sqe_pkg::NUM_SEGS];
  logic [2:0]          slot_r;
  logic [1:0]          chr_r;

  // Combinational results for the item in the input register
  sqe_pkg::seg_t       seg_nxt [sqe_pkg::NUM_SEGS];
  logic [sqe_pkg::NUM_SEGS-1:0] new_mask;
  logic [sqe_pkg::NUM_SEGS-1:0] cur_mask;
  logic                has_out;
  logic [2:0]          first_slot;
  logic [2:0]          next_slot;
  logic                next_found;
  logic                chr_last;
  logic                res_last;
  logic                beat_out;
  logic                drain_done;
  logic                advance;

  logic [7:0]  q;
  logic        triple;
  logic [7:0]  win [8];
  logic [2:0]  total;
  logic [2:0]  sp;
  logic [2:0]  keep;
  logic        stopped;
  logic [1:0]  raw_rem;
  logic [7:0]  h;
  logic [2:0]  len;
  logic        good;
  logic        undec;
  logic        done;

  // Build the output segments and next state for the held item
  always_comb begin
    q      = (dq_r && !sq_r) ? sqe_pkg::CH_SQUOTE : sqe_pkg::CH_DQUOTE;
    triple = nl_r;
    for (int i = 0; i < sqe_pkg::NUM_SEGS; i++) seg_nxt[i] = '0;
    for (int i = 0; i < 8; i++) win[i] = '0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < la_cnt_r) win[i] = la_r[i];
    end
    win[{1'b0, la_cnt_r}] = in_byte_r;
    total   = {1'b0, la_cnt_r} + 3'd1;
    sp      = total;
    keep    = '0;
    stopped = 1'b0;
    raw_rem = 2'd0;
    h       = '0;
    len     = '0;
    good    = 1'b0;
    undec   = 1'b0;
    done    = 1'b0;

    dq_nxt     = dq_r;
    sq_nxt     = sq_r;
    nl_nxt     = nl_r;
    opened_nxt = opened_r;
    la_cnt_nxt = la_cnt_r;
    for (int j = 0; j < 3; j++) la_nxt[j] = la_r[j];

    if (in_op_r == sqe_pkg::OP_SCAN) begin
      // Note quote and newline presence
      if (in_byte_r == sqe_pkg::CH_DQUOTE) dq_nxt = 1'b1;
      if (in_byte_r == sqe_pkg::CH_SQUOTE) sq_nxt = 1'b1;
      if (in_byte_r == sqe_pkg::CH_NEWLINE) nl_nxt = 1'b1;
    end else begin
      // Open the literal on the first emit byte
      if (!opened_r) begin
        seg_nxt[sqe_pkg::SEG_OPEN] = sqe_pkg::quote_seg(q, triple ? 3'd3 : 3'd1);
      end
      opened_nxt = 1'b1;

      // Walk the window: raw UTF-8 runs, escaped bytes, stop on an undecided lead
      for (int i = 0; i < sqe_pkg::WIN_BYTES; i++) begin
        if (!stopped && 3'(i) < total) begin
          h = win[i];
          if (raw_rem != 2'd0) begin
            seg_nxt[i+1] = sqe_pkg::raw_seg(h);
            raw_rem      = raw_rem - 2'd1;
          end else begin
            len   = sqe_pkg::seq_len(h);
            good  = (len != 3'd0);
            undec = 1'b0;
            done  = 1'b0;
            for (int k = 1; k < 4; k++) begin
              if (!done && 3'(k) < len) begin
                if (3'(i + k) >= total) begin
                  done  = 1'b1;
                  good  = 1'b0;
                  undec = !in_eos_r;
                end else if (!sqe_pkg::is_cont(win[i+k])) begin
                  done = 1'b1;
                  good = 1'b0;
                end
              end
            end
            if (undec) begin
              stopped = 1'b1;
              sp      = 3'(i);
            end else if (good) begin
              seg_nxt[i+1] = sqe_pkg::raw_seg(h);
              raw_rem      = 2'(len - 3'd1);
            end else begin
              seg_nxt[i+1] = sqe_pkg::escape_seg(h, q, triple);
            end
          end
        end
      end

      // Hold the undecided tail in the window
      keep       = total - sp;
      la_cnt_nxt = 2'(keep);
      for (int j = 0; j < 3; j++) begin
        la_nxt[j] = (3'(j) < keep) ? win[sp + 3'(j)] : 8'd0;
      end

      // Close the literal and drop all string state
      if (in_eos_r) begin
        seg_nxt[sqe_pkg::SEG_CLOSE] = sqe_pkg::quote_seg(q, triple ? 3'd3 : 3'd1);
        dq_nxt     = 1'b0;
        sq_nxt     = 1'b0;
        nl_nxt     = 1'b0;
        opened_nxt = 1'b0;
        la_cnt_nxt = 2'd0;
        for (int j = 0; j < 3; j++) la_nxt[j] = 8'd0;
      end
    end
  end

  // Segment occupancy and slot search
  always_comb begin
    for (int i = 0; i < sqe_pkg::NUM_SEGS; i++) begin
      new_mask[i] = (seg_nxt[i].len != 3'd0);
      cur_mask[i] = (seg_r[i].len != 3'd0);
    end
    has_out    = |new_mask;
    first_slot = '0;
    next_slot  = '0;
    next_found = 1'b0;
    for (int j = sqe_pkg::NUM_SEGS - 1; j >= 0; j--) begin
      if (new_mask[j]) first_slot = 3'(j);
      if (cur_mask[j] && 3'(j) > slot_r) begin
        next_slot  = 3'(j);
        next_found = 1'b1;
      end
    end
  end

  assign chr_last   = ({1'b0, chr_r} + 3'd1) >= seg_r[slot_r].len;
  assign res_last   = chr_last && !next_found;
  assign beat_out   = out_valid && out_ready;
  assign drain_done = beat_out && res_last;
  assign advance    = in_valid_r && (!has_out || !res_valid_r || drain_done);
  assign in_ready   = !in_valid_r || advance;

  assign out_valid = res_valid_r;
  assign out_char  = seg_r[slot_r].chars[chr_r];
  assign out_final = res_last && (slot_r == sqe_pkg::SEG_CLOSE);

  // Input register: load a beat whenever it is empty or the held one moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_op_r   <= in_operation;
      in_byte_r <= in_text_byte;
      in_eos_r  <= in_end_of_string;
    end
  end

  // String state: advance with each item leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dq_r     <= 1'b0;
      sq_r     <= 1'b0;
      nl_r     <= 1'b0;
      opened_r <= 1'b0;
      la_cnt_r <= 2'd0;
      for (int j = 0; j < 3; j++) la_r[j] <= 8'd0;
    end else if (advance) begin
      dq_r     <= dq_nxt;
      sq_r     <= sq_nxt;
      nl_r     <= nl_nxt;
      opened_r <= opened_nxt;
      la_cnt_r <= la_cnt_nxt;
      for (int j = 0; j < 3; j++) la_r[j] <= la_nxt[j];
    end
  end

  // Serializer: load new segments, else step one character per beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      slot_r      <= '0;
      chr_r       <= '0;
    end else if (advance && has_out) begin
      res_valid_r <= 1'b1;
      slot_r      <= first_slot;
      chr_r       <= '0;
    end else if (beat_out) begin
      if (res_last) begin
        res_valid_r <= 1'b0;
      end else if (chr_last) begin
        slot_r <= next_slot;
        chr_r  <= '0;
      end else begin
        chr_r <= chr_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_out) begin
      for (int i = 0; i < sqe_pkg::NUM_SEGS; i++) seg_r[i] <= seg_nxt[i];
    end
  end

  // Final marker only on the closing quote that ends the result
  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final |-> res_last && seg_r[sqe_pkg::SEG_CLOSE].len != 3'd0)
    else $error("out_final raised away from the last closing quote");

  // A result not yet finished keeps the output valid
  a_drain_continues: assert property (@(posedge clk) disable iff (!rst_n)
    beat_out && !res_last |=> out_valid)
    else $error("result dropped before its last byte");

  // The window only holds bytes once the literal is open
  a_window_opened: assert property (@(posedge clk) disable iff (!rst_n)
    !opened_r |-> la_cnt_r == 2'd0)
    else $error("lookahead bytes held before opening quotes");

  // Reset empties the input register and the output side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_valid_r)
    else $error("valid state survived reset");

endmodule
